/* design/acfr_pkg.sv */
// ----------------------------------------------------------------------------
// acfr_pkg: shared types for the arc center from radius core
// Motion codes, input and result words, and the sideband record that rides
// along the square root and divider pipelines.
// ----------------------------------------------------------------------------
package acfr_pkg;

  // motion codes
  typedef enum logic [1:0] {
    OP_OTHER = 2'd0,
    OP_CW    = 2'd1,
    OP_CCW   = 2'd2
  } op_e;

  localparam logic signed [34:0] SatMax = 35'sh0_7FFF_FFFF;
  localparam logic signed [34:0] SatMin = -35'sh0_8000_0000;
  localparam logic [31:0]        HalfMax = 32'h7FFF_FFFF;

  // input word
  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] radius;
  } in_t;

  // result word
  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] radius_out;
    logic               updated;
    logic               degenerate;
  } out_t;

  // per-item context carried through the pipeline
  typedef struct packed {
    logic               op_cw;
    logic               upd;
    logic               deg;
    logic               lt_x;
    logic               gt_y;
    logic               first;
    logic               r_gt;
    logic signed [31:0] rin;
    logic signed [31:0] rout;
    logic [31:0]        adx;
    logic [31:0]        ady;
    logic signed [32:0] sx;
    logic signed [32:0] sy;
    logic [32:0]        chord;
    logic [31:0]        half;
    logic [31:0]        r_eff;
  } side_t;

  // clamp a widened coordinate to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > SatMax) begin
      r = SatMax[31:0];
    end else if (v < SatMin) begin
      r = SatMin[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* design/acfr_isqrt.sv */
// ----------------------------------------------------------------------------
// acfr_isqrt: pipelined floor square root
// 65-bit radicand, 33-bit root, one root bit resolved per register stage.
// ----------------------------------------------------------------------------
module acfr_isqrt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [64:0]       value_i,
  input  acfr_pkg::side_t   side_i,
  output logic              valid_o,
  output logic [32:0]       root_o,
  output acfr_pkg::side_t   side_o
);

  localparam int Steps = 33;

  logic [Steps-1:0] vld_q;
  logic [64:0]      rem_q  [Steps];
  logic [32:0]      res_q  [Steps];
  acfr_pkg::side_t  side_q [Steps];

  for (genvar i = 0; i < Steps; i++) begin : g_step
    localparam int B = Steps - 1 - i;
    logic            vld_in;
    logic [64:0]     rem_in;
    logic [32:0]     res_in;
    acfr_pkg::side_t side_in;
    logic [66:0]     trial;
    logic            take;

    if (i == 0) begin : g_head
      assign vld_in  = valid_i;
      assign rem_in  = value_i;
      assign res_in  = '0;
      assign side_in = side_i;
    end else begin : g_body
      assign vld_in  = vld_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign res_in  = res_q[i-1];
      assign side_in = side_q[i-1];
    end

    // (res + 2^B)^2 - res^2 against what is left of the radicand
    assign trial = ({34'd0, res_in} << (B + 1)) + (67'd1 << (2 * B));
    assign take  = ({2'b00, rem_in} >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[i] <= side_in;
      if (take) begin
        rem_q[i] <= rem_in - trial[64:0];
        res_q[i] <= res_in | (33'd1 << B);
      end else begin
        rem_q[i] <= rem_in;
        res_q[i] <= res_in;
      end
    end
  end

  assign valid_o = vld_q[Steps-1];
  assign root_o  = res_q[Steps-1];
  assign side_o  = side_q[Steps-1];

endmodule

/* design/acfr_div.sv */
// ----------------------------------------------------------------------------
// acfr_div: pipelined dual restoring divider
// Two 64-bit numerators over the chord length from the sideband, 32-bit
// quotients, one quotient bit per register stage in each lane.
// ----------------------------------------------------------------------------
module acfr_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [63:0]       num_a_i,
  input  logic [63:0]       num_b_i,
  input  acfr_pkg::side_t   side_i,
  output logic              valid_o,
  output logic [31:0]       quo_a_o,
  output logic [31:0]       quo_b_o,
  output acfr_pkg::side_t   side_o
);

  localparam int Steps = 32;

  logic [Steps-1:0] vld_q;
  logic [32:0]      rem_q  [Steps][2];
  logic [31:0]      low_q  [Steps][2];
  logic [31:0]      quo_q  [Steps][2];
  acfr_pkg::side_t  side_q [Steps];

  for (genvar i = 0; i < Steps; i++) begin : g_step
    logic            vld_in;
    acfr_pkg::side_t side_in;
    logic [33:0]     den;

    if (i == 0) begin : g_head
      assign vld_in  = valid_i;
      assign side_in = side_i;
    end else begin : g_body
      assign vld_in  = vld_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign den = {1'b0, side_in.chord};

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [32:0] rem_in;
      logic [31:0] low_in;
      logic [31:0] quo_in;
      logic [33:0] trial;

      // the quotient fits in 32 bits, so the upper numerator half is below the divisor
      if (i == 0) begin : g_head
        assign rem_in = (l == 0) ? {1'b0, num_a_i[63:32]} : {1'b0, num_b_i[63:32]};
        assign low_in = (l == 0) ? num_a_i[31:0] : num_b_i[31:0];
        assign quo_in = '0;
      end else begin : g_body
        assign rem_in = rem_q[i-1][l];
        assign low_in = low_q[i-1][l];
        assign quo_in = quo_q[i-1][l];
      end

      assign trial = {rem_in, low_in[31]};

      always_ff @(posedge clk_i) begin
        low_q[i][l] <= {low_in[30:0], 1'b0};
        if (trial >= den) begin
          rem_q[i][l] <= 33'(trial - den);
          quo_q[i][l] <= {quo_in[30:0], 1'b1};
        end else begin
          rem_q[i][l] <= trial[32:0];
          quo_q[i][l] <= {quo_in[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[i] <= side_in;
    end
  end

  assign valid_o = vld_q[Steps-1];
  assign quo_a_o = quo_q[Steps-1][0];
  assign quo_b_o = quo_q[Steps-1][1];
  assign side_o  = side_q[Steps-1];

endmodule

/* design/arc_center_from_radius_core.sv */
// Throughput: one word per cycle; busy stays low, the pipeline never stalls.
// Most of the latency comes from two 33-stage square roots and a 32-stage divider.
// Reset clears all valid bits; no result strobe until a new word is accepted.
// ----------------------------------------------------------------------------
// arc_center_from_radius_core: arc center from a signed radius
// Midpoint, chord length, radius clamp, center offset and mirror selection,
// all in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
module arc_center_from_radius_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  acfr_pkg::in_t   in_word_i,
  output logic            result_valid_o,
  output acfr_pkg::out_t  result_o
);

  assign busy = 1'b0;

  // stage 1: differences, order flags, degenerate check
  logic               s1_vld_q;
  acfr_pkg::side_t    s1_side_q, s1_side_d;
  logic signed [32:0] dx, dy;
  logic               arc;

  always_comb begin
    dx  = 33'(in_word_i.end_x) - 33'(in_word_i.start_x);
    dy  = 33'(in_word_i.end_y) - 33'(in_word_i.start_y);
    arc = ((in_word_i.opcode == acfr_pkg::OP_CW) || (in_word_i.opcode == acfr_pkg::OP_CCW))
          && (in_word_i.radius != 32'sd0);
    s1_side_d       = '0;
    s1_side_d.op_cw = (in_word_i.opcode == acfr_pkg::OP_CW);
    s1_side_d.lt_x  = (in_word_i.start_x < in_word_i.end_x);
    s1_side_d.gt_y  = (in_word_i.start_y > in_word_i.end_y);
    s1_side_d.adx   = dx[32] ? 32'(-dx) : dx[31:0];
    s1_side_d.ady   = dy[32] ? 32'(-dy) : dy[31:0];
    s1_side_d.deg   = arc && (dx == 33'sd0) && (dy == 33'sd0);
    s1_side_d.upd   = arc && !((dx == 33'sd0) && (dy == 33'sd0));
    s1_side_d.rin   = in_word_i.radius;
    s1_side_d.rout  = in_word_i.radius;
    // low coordinate for now, midpoint added next stage
    s1_side_d.sx    = s1_side_d.lt_x ? 33'(in_word_i.start_x) : 33'(in_word_i.end_x);
    s1_side_d.sy    = s1_side_d.gt_y ? 33'(in_word_i.end_y) : 33'(in_word_i.start_y);
  end

  // stage 2: midpoint and squares
  logic            s2_vld_q;
  acfr_pkg::side_t s2_side_q, s2_side_d;
  logic [63:0]     s2_sqx_q, s2_sqy_q;

  always_comb begin
    s2_side_d    = s1_side_q;
    s2_side_d.sx = s1_side_q.sx + $signed({2'b00, s1_side_q.adx[31:1]});
    s2_side_d.sy = s1_side_q.sy + $signed({2'b00, s1_side_q.ady[31:1]});
  end

  // stage 3: sum of squares into the chord root
  logic            s3_vld_q;
  acfr_pkg::side_t s3_side_q;
  logic [64:0]     s3_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_side_q <= s1_side_d;
    s2_side_q <= s2_side_d;
    s2_sqx_q  <= s1_side_q.adx * s1_side_q.adx;
    s2_sqy_q  <= s1_side_q.ady * s1_side_q.ady;
    s3_side_q <= s2_side_q;
    s3_sum_q  <= {1'b0, s2_sqx_q} + {1'b0, s2_sqy_q};
  end

  // chord length
  logic            q1_vld;
  logic [32:0]     q1_root;
  acfr_pkg::side_t q1_side;

  acfr_isqrt u_chord_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_vld_q),
    .value_i (s3_sum_q),
    .side_i  (s3_side_q),
    .valid_o (q1_vld),
    .root_o  (q1_root),
    .side_o  (q1_side)
  );

  // stage 4: half chord, radius clamp, center choice
  logic            s4_vld_q;
  acfr_pkg::side_t s4_side_q, s4_side_d;
  logic [31:0]     rmag, half;
  logic            small_r;

  always_comb begin
    half      = q1_root[32:1];
    rmag      = q1_side.rin[31] ? 32'(-q1_side.rin) : q1_side.rin[31:0];
    small_r   = (rmag < half);
    s4_side_d       = q1_side;
    s4_side_d.chord = q1_root;
    s4_side_d.half  = half;
    s4_side_d.r_eff = small_r ? half : rmag;
    s4_side_d.r_gt  = (rmag > half);
    if (q1_side.upd && small_r) begin
      s4_side_d.rout = (half > acfr_pkg::HalfMax) ? $signed(acfr_pkg::HalfMax) : $signed(half);
    end
    s4_side_d.first = q1_side.op_cw ? !s4_side_d.rout[31] : s4_side_d.rout[31];
  end

  // stage 5: squares of radius and half chord
  logic            s5_vld_q;
  acfr_pkg::side_t s5_side_q;
  logic [63:0]     s5_rr_q, s5_hh_q;

  // stage 6: offset radicand
  logic            s6_vld_q;
  acfr_pkg::side_t s6_side_q;
  logic [64:0]     s6_rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
    end else begin
      s4_vld_q <= q1_vld;
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_side_q <= s4_side_d;
    s5_side_q <= s4_side_q;
    s5_rr_q   <= s4_side_q.r_eff * s4_side_q.r_eff;
    s5_hh_q   <= s4_side_q.half * s4_side_q.half;
    s6_side_q <= s5_side_q;
    s6_rad_q  <= s5_side_q.r_gt ? {1'b0, s5_rr_q - s5_hh_q} : 65'd0;
  end

  // offset length h
  logic            q2_vld;
  logic [32:0]     q2_root;
  acfr_pkg::side_t q2_side;

  acfr_isqrt u_offset_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s6_vld_q),
    .value_i (s6_rad_q),
    .side_i  (s6_side_q),
    .valid_o (q2_vld),
    .root_o  (q2_root),
    .side_o  (q2_side)
  );

  // stage 7: h times each chord component
  logic            s7_vld_q;
  acfr_pkg::side_t s7_side_q;
  logic [63:0]     s7_pa_q, s7_pb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_vld_q <= 1'b0;
    end else begin
      s7_vld_q <= q2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    s7_side_q <= q2_side;
    s7_pa_q   <= q2_root[31:0] * q2_side.ady;
    s7_pb_q   <= q2_root[31:0] * q2_side.adx;
  end

  // offsets c and d over the chord
  logic            dv_vld;
  logic [31:0]     off_c, off_d;
  acfr_pkg::side_t dv_side;

  acfr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s7_vld_q),
    .num_a_i (s7_pa_q),
    .num_b_i (s7_pb_q),
    .side_i  (s7_side_q),
    .valid_o (dv_vld),
    .quo_a_o (off_c),
    .quo_b_o (off_d),
    .side_o  (dv_side)
  );

  // output stage: pick the center, saturate, build the result word
  logic               out_vld_q;
  acfr_pkg::out_t     out_q, out_d;
  logic               minus_x, minus_y;
  logic signed [34:0] cx_w, cy_w, ox, oy;

  always_comb begin
    minus_x = (dv_side.gt_y == dv_side.first);
    minus_y = (dv_side.lt_x == dv_side.first);
    cx_w    = $signed({3'b000, off_c});
    cy_w    = $signed({3'b000, off_d});
    ox      = minus_x ? 35'(dv_side.sx) - cx_w : 35'(dv_side.sx) + cx_w;
    oy      = minus_y ? 35'(dv_side.sy) - cy_w : 35'(dv_side.sy) + cy_w;
    out_d            = '0;
    out_d.radius_out = dv_side.rout;
    out_d.updated    = dv_side.upd;
    out_d.degenerate = dv_side.deg;
    if (dv_side.upd) begin
      out_d.center_x = acfr_pkg::sat32(ox);
      out_d.center_y = acfr_pkg::sat32(oy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign result_valid_o = out_vld_q;
  assign result_o       = out_q;

endmodule
